// File: hdl/maop_pkg.sv
`timescale 1ns / 1ps

package maop_pkg;

	// Field widths
	localparam int TS_W    = 32;
	localparam int LVL_W   = 10;
	localparam int VAL_W   = 11;
	localparam int ANG_W   = 8;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;

	// Divider geometry: |90 * (wr - wl)| <= 92070 fits 17 bits, den <= 3072 fits 12
	localparam int DVD_W     = 17;
	localparam int DEN_W     = 12;
	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Register indexes
	localparam logic [IDX_W-1:0] REG_ACTIVE    = 3'd0;
	localparam logic [IDX_W-1:0] REG_PERIOD    = 3'd1;
	localparam logic [IDX_W-1:0] REG_THR_FRONT = 3'd2;
	localparam logic [IDX_W-1:0] REG_THR_LEFT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_THR_RIGHT = 3'd4;

	// Result selection: one code per mic, then the orientation word
	localparam logic [1:0] SEL_FRONT  = 2'd0;
	localparam logic [1:0] SEL_LEFT   = 2'd1;
	localparam logic [1:0] SEL_RIGHT  = 2'd2;
	localparam logic [1:0] SEL_ORIENT = 2'd3;

	// Result kinds
	localparam logic KIND_ALERT  = 1'b0;
	localparam logic KIND_ORIENT = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       start;
		logic       div_step;
		logic       smooth;
		logic       load_out;
		logic [1:0] out_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic       go;
		logic [2:0] alert;
		logic       slot_free;
	} sts_t;

endpackage

// File: hdl/maop_dp.sv
`timescale 1ns / 1ps

module maop_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  maop_pkg::cmd_t                     cmd,
	output maop_pkg::sts_t                     sts,
	input  logic                               cfg_wr_en,
	input  logic [maop_pkg::IDX_W-1:0]         cfg_index,
	input  logic [maop_pkg::CFG_W-1:0]         cfg_data,
	input  logic [maop_pkg::TS_W-1:0]          now_ms,
	input  logic [maop_pkg::LVL_W-1:0]         peak_front,
	input  logic [maop_pkg::LVL_W-1:0]         peak_left,
	input  logic [maop_pkg::LVL_W-1:0]         peak_right,
	input  logic [maop_pkg::LVL_W-1:0]         level_front,
	input  logic [maop_pkg::LVL_W-1:0]         level_left,
	input  logic [maop_pkg::LVL_W-1:0]         level_right,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic                               kind,
	output logic [1:0]                         mic_index,
	output logic signed [maop_pkg::VAL_W-1:0]  value,
	output logic                               last_of_run
);

	// Configuration registers
	logic                          active_q;
	logic [maop_pkg::TS_W-1:0]     period_q;
	logic [maop_pkg::LVL_W-1:0]    thr_front_q;
	logic [maop_pkg::LVL_W-1:0]    thr_left_q;
	logic [maop_pkg::LVL_W-1:0]    thr_right_q;

	// Captured poll
	logic [maop_pkg::TS_W-1:0]     now_q;
	logic [maop_pkg::LVL_W-1:0]    peak_front_q;
	logic [maop_pkg::LVL_W-1:0]    peak_left_q;
	logic [maop_pkg::LVL_W-1:0]    peak_right_q;
	logic [maop_pkg::LVL_W-1:0]    level_front_q;
	logic [maop_pkg::LVL_W-1:0]    level_left_q;
	logic [maop_pkg::LVL_W-1:0]    level_right_q;

	// Block state
	logic [maop_pkg::TS_W-1:0]     last_pub_q;
	logic signed [maop_pkg::ANG_W-1:0] smooth_q;

	// Divider
	logic [maop_pkg::DVD_W-1:0]    dvd_q;
	logic [maop_pkg::DVD_W-1:0]    quo_q;
	logic [maop_pkg::DEN_W-1:0]    rem_q;
	logic [maop_pkg::DEN_W-1:0]    den_q;
	logic                          neg_q;

	// Output word register
	logic                          out_valid_q;
	logic                          kind_q;
	logic [1:0]                    mic_q;
	logic signed [maop_pkg::VAL_W-1:0] value_q;
	logic                          last_q;

	logic [maop_pkg::TS_W-1:0]     elapsed;
	logic signed [maop_pkg::LVL_W:0]   diff;
	logic signed [maop_pkg::DVD_W:0]   num;
	logic [maop_pkg::DVD_W:0]          num_mag;
	logic [maop_pkg::DEN_W-1:0]        den;
	logic [maop_pkg::DEN_W:0]          rem_sh;
	logic                              ge;
	logic signed [maop_pkg::ANG_W-1:0] ang;
	logic signed [9:0]                 t;
	logic [9:0]                        t_mag;
	logic [6:0]                        t_q;
	logic signed [maop_pkg::ANG_W-1:0] sm;

	function automatic logic signed [maop_pkg::VAL_W-1:0] sm_out_ext(
		input logic signed [maop_pkg::ANG_W-1:0] a
	);
		return maop_pkg::VAL_W'(a);
	endfunction

	// Status toward the controller
	assign elapsed       = now_q - last_pub_q;
	assign sts.go        = active_q && (elapsed >= period_q);
	assign sts.alert[0]  = peak_front_q > thr_front_q;
	assign sts.alert[1]  = peak_left_q  > thr_left_q;
	assign sts.alert[2]  = peak_right_q > thr_right_q;
	assign sts.slot_free = !out_valid_q || !out_stall;

	// Weighted mean numerator and denominator; the +1 of each weight cancels in the difference
	assign diff    = $signed({1'b0, level_right_q}) - $signed({1'b0, level_left_q});
	assign num     = (maop_pkg::DVD_W + 1)'(diff * 18'sd90);
	assign num_mag = num[maop_pkg::DVD_W] ? (maop_pkg::DVD_W + 1)'(-num)
	                                      : (maop_pkg::DVD_W + 1)'(num);
	assign den     = maop_pkg::DEN_W'(level_front_q) + maop_pkg::DEN_W'(level_left_q)
	               + maop_pkg::DEN_W'(level_right_q) + maop_pkg::DEN_W'(3);

	// One restoring step
	assign rem_sh = {rem_q, dvd_q[maop_pkg::DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	// Smoothing: (3*last + angle) / 4, truncated toward zero
	assign ang   = neg_q ? -$signed({1'b0, quo_q[6:0]}) : $signed({1'b0, quo_q[6:0]});
	assign t     = ($signed(10'(smooth_q)) <<< 1) + $signed(10'(smooth_q)) + $signed(10'(ang));
	assign t_mag = t[9] ? 10'(-t) : 10'(t);
	assign t_q   = t_mag[8:2];
	assign sm    = t[9] ? -$signed({1'b0, t_q}) : $signed({1'b0, t_q});

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b1;
			period_q    <= 32'd100;
			thr_front_q <= 10'd512;
			thr_left_q  <= 10'd512;
			thr_right_q <= 10'd512;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				maop_pkg::REG_ACTIVE:    active_q    <= cfg_data[0];
				maop_pkg::REG_PERIOD:    period_q    <= cfg_data;
				maop_pkg::REG_THR_FRONT: thr_front_q <= cfg_data[maop_pkg::LVL_W-1:0];
				maop_pkg::REG_THR_LEFT:  thr_left_q  <= cfg_data[maop_pkg::LVL_W-1:0];
				maop_pkg::REG_THR_RIGHT: thr_right_q <= cfg_data[maop_pkg::LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Poll capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q         <= now_ms;
			peak_front_q  <= peak_front;
			peak_left_q   <= peak_left;
			peak_right_q  <= peak_right;
			level_front_q <= level_front;
			level_left_q  <= level_left;
			level_right_q <= level_right;
		end
	end

	// Publish timestamp and smoothed angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pub_q <= '0;
			smooth_q   <= '0;
		end else begin
			if (cmd.start)
				last_pub_q <= now_q;
			if (cmd.smooth)
				smooth_q <= sm;
		end
	end

	// Divider registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= num_mag[maop_pkg::DVD_W-1:0];
			den_q <= den;
			neg_q <= num[maop_pkg::DVD_W];
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[maop_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[maop_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? maop_pkg::DEN_W'(rem_sh - {1'b0, den_q})
			            : rem_sh[maop_pkg::DEN_W-1:0];
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mic_q <= cmd.out_sel;
			last_q <= 1'b0;
			kind_q <= maop_pkg::KIND_ALERT;
			case (cmd.out_sel)
				maop_pkg::SEL_FRONT: value_q <= $signed({1'b0, peak_front_q});
				maop_pkg::SEL_LEFT:  value_q <= $signed({1'b0, peak_left_q});
				maop_pkg::SEL_RIGHT: value_q <= $signed({1'b0, peak_right_q});
				default: begin
					mic_q   <= maop_pkg::SEL_FRONT;
					kind_q  <= maop_pkg::KIND_ORIENT;
					last_q  <= 1'b1;
					value_q <= maop_pkg::VAL_W'(sm_out_ext(smooth_q));
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign mic_index   = mic_q;
	assign value       = value_q;
	assign last_of_run = last_q;

	// Quotient of the angle division never exceeds 90 degrees
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.smooth |-> quo_q <= maop_pkg::DVD_W'(90))
		else $error("angle quotient out of range");

	// Smoothed angle stays within -90..90
	a_sm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(smooth_q >= -8'sd90) && (smooth_q <= 8'sd90))
		else $error("smoothed angle out of range");

	// A word is never loaded over one that is stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.slot_free)
		else $error("output word overwritten");

endmodule

// File: hdl/maop_ctrl.sv
`timescale 1ns / 1ps

module maop_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  maop_pkg::sts_t  sts,
	output maop_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_SMOOTH = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0]                 state_q, state_d;
	logic [maop_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]                 sel_q, sel_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.out_sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.go) begin
					cmd.start = 1'b1;
					cnt_d     = '0;
					state_d   = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == maop_pkg::CNT_W'(maop_pkg::DIV_STEPS - 1))
					state_d = S_SMOOTH;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_SMOOTH: begin
				cmd.smooth = 1'b1;
				sel_d      = maop_pkg::SEL_FRONT;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (sel_q == maop_pkg::SEL_ORIENT) begin
					if (sts.slot_free) begin
						cmd.load_out = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (!sts.alert[sel_q]) begin
					// mic below threshold: skip it
					sel_d = sel_q + 2'd1;
				end else if (sts.slot_free) begin
					cmd.load_out = 1'b1;
					sel_d        = sel_q + 2'd1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= maop_pkg::SEL_FRONT;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
		end
	end

	// The orientation word closes the round
	a_orient_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && (cmd.out_sel == maop_pkg::SEL_ORIENT)) |=> state_q == S_IDLE)
		else $error("round did not end after orientation word");

	// Divider step count stays in range
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> cnt_q < maop_pkg::CNT_W'(maop_pkg::DIV_STEPS))
		else $error("divider step count out of range");

	// A new poll is captured only from idle
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_CHECK)
		else $error("capture outside idle");

endmodule

// File: hdl/mic_alert_orientation_publisher_top.sv
`timescale 1ns / 1ps

// Microphone alert and orientation publisher.
// Input channel (in_valid / in_stall): one poll word per transfer, carrying a
// millisecond timestamp and the peak and RMS levels of the front, left and
// right mics. Output channel (out_valid / out_stall): result words, alerts
// first (front, left, right, only those above threshold), then one
// orientation word with last_of_run set.
// A poll is taken only while the controller is idle. A poll that does not
// publish (block inactive or period not yet elapsed) returns to idle from the
// check state. A publishing poll passes the check state, the serial angle
// divider (one quotient bit per cycle), the smoothing state and the steps
// through the three mics and the orientation word (one per cycle, alerting or
// not; a word waits while the output register holds a stalled one).
// Results leave through one output register; while the receiver stalls, the
// register holds its word and the controller waits before loading the next.
// A new poll can be accepted while the last word of a round still waits.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once.
// Reset: active = 1, period = 100 ms, thresholds = 512, last publish time
// and smoothed angle cleared, no word pending.

module mic_alert_orientation_publisher_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [maop_pkg::IDX_W-1:0]         cfg_index,
	input  logic [maop_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [maop_pkg::TS_W-1:0]          now_ms,
	input  logic [maop_pkg::LVL_W-1:0]         peak_front,
	input  logic [maop_pkg::LVL_W-1:0]         peak_left,
	input  logic [maop_pkg::LVL_W-1:0]         peak_right,
	input  logic [maop_pkg::LVL_W-1:0]         level_front,
	input  logic [maop_pkg::LVL_W-1:0]         level_left,
	input  logic [maop_pkg::LVL_W-1:0]         level_right,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kind,
	output logic [1:0]                         mic_index,
	output logic signed [maop_pkg::VAL_W-1:0]  value,
	output logic                               last_of_run
);

	maop_pkg::cmd_t cmd;
	maop_pkg::sts_t sts;

	maop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	maop_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.now_ms      (now_ms),
		.peak_front  (peak_front),
		.peak_left   (peak_left),
		.peak_right  (peak_right),
		.level_front (level_front),
		.level_left  (level_left),
		.level_right (level_right),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.kind        (kind),
		.mic_index   (mic_index),
		.value       (value),
		.last_of_run (last_of_run)
	);

endmodule

// File: tb/sv/maop_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each publish round
// and checks every result word against the oldest prediction.
module maop_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [maop_pkg::IDX_W-1:0]          cfg_index,
	input  logic [maop_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [maop_pkg::TS_W-1:0]           now_ms,
	input  logic [maop_pkg::LVL_W-1:0]          peak_front,
	input  logic [maop_pkg::LVL_W-1:0]          peak_left,
	input  logic [maop_pkg::LVL_W-1:0]          peak_right,
	input  logic [maop_pkg::LVL_W-1:0]          level_front,
	input  logic [maop_pkg::LVL_W-1:0]          level_left,
	input  logic [maop_pkg::LVL_W-1:0]          level_right,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                kind,
	input  logic [1:0]                          mic_index,
	input  logic signed [maop_pkg::VAL_W-1:0]   value,
	input  logic                                last_of_run,
	output int                                  fail_count,
	output int                                  pending
);

	localparam logic [maop_pkg::TS_W-1:0]  RST_PERIOD  = 32'd100;
	localparam logic [maop_pkg::LVL_W-1:0] RST_THR     = 10'd512;
	localparam int                         ANG_LEFT    = -90;
	localparam int                         ANG_RIGHT   = 90;
	localparam int                         SMOOTH_KEEP = 3;
	localparam int                         SMOOTH_DIV  = 4;

	typedef struct packed {
		logic                              kind;
		logic [1:0]                        mic;
		logic signed [maop_pkg::VAL_W-1:0] val;
		logic                              last;
	} word_t;

	word_t                             expected_words[$];
	word_t                             oldest;

	// Shadow registers and round state
	logic                              cfg_active;
	logic [maop_pkg::TS_W-1:0]         cfg_period;
	logic [maop_pkg::LVL_W-1:0]        cfg_thr[3];
	logic [maop_pkg::TS_W-1:0]         last_pub_ms;
	logic signed [maop_pkg::ANG_W-1:0] smooth_ang;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// One poll: alerts above threshold, then the smoothed orientation word
	task automatic predict_round(input logic [maop_pkg::TS_W-1:0] now,
			input logic [2:0][maop_pkg::LVL_W-1:0] pk,
			input logic [2:0][maop_pkg::LVL_W-1:0] lv);
		word_t w;
		int    wt[3];
		int    num;
		int    den;
		int    ang;
		int    sm;
		if (!cfg_active)
			return;
		// elapsed time wraps modulo 2^32
		if (now - last_pub_ms < cfg_period)
			return;
		last_pub_ms = now;
		for (int i = 0; i < 3; i++) begin
			wt[i] = int'(lv[i]) + 1;
			if (pk[i] > cfg_thr[i]) begin
				w.kind = maop_pkg::KIND_ALERT;
				w.mic  = maop_pkg::SEL_FRONT + 2'(i);
				w.val  = {1'b0, pk[i]};
				w.last = 1'b0;
				expected_words.push_back(w);
			end
		end
		// weighted mean of 0 / -90 / +90, integer division truncates toward zero
		num = ANG_LEFT * wt[1] + ANG_RIGHT * wt[2];
		den = wt[0] + wt[1] + wt[2];
		ang = num / den;
		sm  = (SMOOTH_KEEP * int'(smooth_ang) + ang) / SMOOTH_DIV;
		smooth_ang = sm[maop_pkg::ANG_W-1:0];
		w.kind = maop_pkg::KIND_ORIENT;
		w.mic  = maop_pkg::SEL_FRONT;
		w.val  = sm[maop_pkg::VAL_W-1:0];
		w.last = 1'b1;
		expected_words.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_active  = 1'b1;
			cfg_period  = RST_PERIOD;
			cfg_thr[0]  = RST_THR;
			cfg_thr[1]  = RST_THR;
			cfg_thr[2]  = RST_THR;
			last_pub_ms = '0;
			smooth_ang  = '0;
			fail_count  = 0;
			expected_words.delete();
		end else begin
			// register writes, values masked to register width
			if (cfg_wr_en) begin
				case (cfg_index)
					maop_pkg::REG_ACTIVE:    cfg_active = cfg_data[0];
					maop_pkg::REG_PERIOD:    cfg_period = cfg_data[maop_pkg::TS_W-1:0];
					maop_pkg::REG_THR_FRONT: cfg_thr[0] = cfg_data[maop_pkg::LVL_W-1:0];
					maop_pkg::REG_THR_LEFT:  cfg_thr[1] = cfg_data[maop_pkg::LVL_W-1:0];
					maop_pkg::REG_THR_RIGHT: cfg_thr[2] = cfg_data[maop_pkg::LVL_W-1:0];
					default: ;
				endcase
			end

			// result word against oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word kind %0d mic %0d value %0d",
						kind, mic_index, value));
				end else begin
					oldest = expected_words.pop_front();
					if (kind !== oldest.kind)
						report_mismatch($sformatf("kind: got %0d, want %0d", kind, oldest.kind));
					if (mic_index !== oldest.mic)
						report_mismatch($sformatf("mic_index: got %0d, want %0d",
							mic_index, oldest.mic));
					if (value !== oldest.val)
						report_mismatch($sformatf("value: got %0d, want %0d", value, oldest.val));
					if (last_of_run !== oldest.last)
						report_mismatch($sformatf("last_of_run: got %0d, want %0d",
							last_of_run, oldest.last));
				end
			end

			// accepted poll word
			if (in_valid && !in_stall)
				predict_round(now_ms, {peak_right, peak_left, peak_front},
					{level_right, level_left, level_front});
		end
		pending = expected_words.size();
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int HALF_PERIOD   = 2;
	localparam int RST_CYCLES    = 5;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_PCT      = 25;
	localparam int HOLD_CYCLES   = 400;
	localparam int N_PHASES      = 6;
	localparam int PHASE_ITEMS   = 34;
	localparam int TIMEOUT_NS    = 2_000_000;

	localparam logic [maop_pkg::LVL_W-1:0] LVL_MAX    = '1;
	localparam logic [maop_pkg::TS_W-1:0]  PERIOD_MAX = '1;
	localparam logic [maop_pkg::CFG_W-1:0] LVL_MASK   = maop_pkg::CFG_W'(LVL_MAX);

	typedef struct packed {
		logic [maop_pkg::TS_W-1:0]          now;
		logic [2:0][maop_pkg::LVL_W-1:0]    peak;
		logic [2:0][maop_pkg::LVL_W-1:0]    level;
	} poll_t;

	logic                               clk         = 1'b0;
	logic                               arst_n      = 1'b0;
	logic                               cfg_wr_en   = 1'b0;
	logic [maop_pkg::IDX_W-1:0]         cfg_index   = '0;
	logic [maop_pkg::CFG_W-1:0]         cfg_data    = '0;
	logic                               in_valid    = 1'b0;
	logic                               in_stall;
	logic [maop_pkg::TS_W-1:0]          now_ms      = '0;
	logic [maop_pkg::LVL_W-1:0]         peak_front  = '0;
	logic [maop_pkg::LVL_W-1:0]         peak_left   = '0;
	logic [maop_pkg::LVL_W-1:0]         peak_right  = '0;
	logic [maop_pkg::LVL_W-1:0]         level_front = '0;
	logic [maop_pkg::LVL_W-1:0]         level_left  = '0;
	logic [maop_pkg::LVL_W-1:0]         level_right = '0;
	logic                               out_valid;
	logic                               out_stall   = 1'b0;
	logic                               kind;
	logic [1:0]                         mic_index;
	logic signed [maop_pkg::VAL_W-1:0]  value;
	logic                               last_of_run;

	int                       fail_count;
	int                       pending;
	bit                       tx_idle        = 1'b1;
	bit                       rx_idle        = 1'b1;
	int                       rx_hold_cycles = 0;

	mic_alert_orientation_publisher_top i_dut (.*);

	maop_checker i_checker (.*);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	initial begin
		#TIMEOUT_NS;
		$display("tb_top failed");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= rx_idle && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	function automatic logic [maop_pkg::LVL_W-1:0] rand_lvl();
		case ($urandom_range(7))
			0: return '0;
			1: return LVL_MAX;
			default: return maop_pkg::LVL_W'($urandom_range(LVL_MAX));
		endcase
	endfunction

	task automatic write_reg(input logic [maop_pkg::IDX_W-1:0] idx,
			input logic [maop_pkg::CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one poll word, hold it until accepted
	task automatic send_poll(input poll_t p);
		while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		now_ms      <= p.now;
		peak_front  <= p.peak[0];
		peak_left   <= p.peak[1];
		peak_right  <= p.peak[2];
		level_front <= p.level[0];
		level_left  <= p.level[1];
		level_right <= p.level[2];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic poll(input logic [maop_pkg::TS_W-1:0] now,
			input logic [maop_pkg::LVL_W-1:0] pf, pl, pr,
			input logic [maop_pkg::LVL_W-1:0] lf, ll, lr);
		poll_t p;
		p.now   = now;
		p.peak  = {pr, pl, pf};
		p.level = {lr, ll, lf};
		send_poll(p);
	endtask

	task automatic rand_poll(input logic [maop_pkg::TS_W-1:0] now);
		poll(now, rand_lvl(), rand_lvl(), rand_lvl(), rand_lvl(), rand_lvl(), rand_lvl());
	endtask

	// Block is idle once every predicted word is out and the controller is done
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_spare();
		write_reg(maop_pkg::IDX_W'($urandom_range(int'(maop_pkg::REG_THR_RIGHT) + 1,
			2**maop_pkg::IDX_W - 1)), $urandom());
	endtask

	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: period 100, thresholds 512
		poll(32'd0, LVL_MAX, LVL_MAX, LVL_MAX, '0, '0, '0);          // too early
		poll(32'd100, LVL_MAX, 10'd513, 10'd512, '0, '0, '0);       // alert at threshold edge
		poll(32'd150, LVL_MAX, LVL_MAX, LVL_MAX, '0, '0, '0);        // too early
		poll(32'd200, '0, '0, '0, '0, LVL_MAX, '0);                  // full left
		poll(32'd300, 10'd600, 10'd700, 10'd800, '0, '0, LVL_MAX);   // full right, all alert
		poll(32'd400, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX);
		poll(32'd500, '0, '0, '0, '0, '0, '0);
		// timestamp wrap: 99 ms then 100 ms past the last publish
		poll(32'hFFFF_FFF0, 10'd900, '0, 10'd900, 10'd17, 10'd300, 10'd5);
		poll(32'h0000_0053, LVL_MAX, LVL_MAX, LVL_MAX, '0, '0, '0);
		poll(32'h0000_0054, '0, LVL_MAX, '0, 10'd700, 10'd1, 10'd900);
		drain_results();

		// inactive, with upper data bits set
		write_reg(maop_pkg::REG_ACTIVE, 32'hFFFF_FFFE);
		poll(32'd100_000, LVL_MAX, LVL_MAX, LVL_MAX, '0, '0, '0);
		drain_results();

		// zero period: every poll publishes, even one back in time
		write_reg(maop_pkg::REG_ACTIVE, 32'h1);
		write_reg(maop_pkg::REG_PERIOD, '0);
		for (int r = int'(maop_pkg::REG_THR_RIGHT) + 1; r < 2**maop_pkg::IDX_W; r++)
			write_reg(maop_pkg::IDX_W'(r), $urandom());
		poll(32'd5000, 10'd513, '0, '0, '0, LVL_MAX, '0);
		poll(32'd5000, '0, '0, 10'd513, '0, LVL_MAX, '0);
		poll(32'd10, '0, '0, '0, '0, '0, LVL_MAX);
		drain_results();

		// largest period: only a poll one ms behind the last publish goes out
		write_reg(maop_pkg::REG_PERIOD, PERIOD_MAX);
		poll(32'd6000, LVL_MAX, LVL_MAX, LVL_MAX, '0, '0, '0);
		poll(32'd9, LVL_MAX, LVL_MAX, LVL_MAX, 10'd3, 10'd400, 10'd2);
		drain_results();

		// threshold extremes, upper data bits masked off
		write_reg(maop_pkg::REG_PERIOD, '0);
		write_reg(maop_pkg::REG_THR_FRONT, ~LVL_MASK);
		write_reg(maop_pkg::REG_THR_LEFT, '0);
		write_reg(maop_pkg::REG_THR_RIGHT, LVL_MASK);
		poll(32'd20, '0, 10'd1, LVL_MAX, rand_lvl(), rand_lvl(), rand_lvl());
		poll(32'd21, 10'd1, '0, LVL_MAX, rand_lvl(), rand_lvl(), rand_lvl());
		rand_poll(32'd22);
		drain_results();

		// random phases, each with its own register setting
		for (int ph = 0; ph < N_PHASES; ph++) begin
			logic [maop_pkg::TS_W-1:0]  period;
			logic [maop_pkg::TS_W-1:0]  now;
			logic [maop_pkg::LVL_W-1:0] thr;
			int                         off;
			case (ph)
				0: period = 32'd100;
				1: period = '0;
				2: period = maop_pkg::TS_W'($urandom_range(1, 20));
				default: period = maop_pkg::TS_W'($urandom_range(0, 500));
			endcase
			write_reg(maop_pkg::REG_ACTIVE, $urandom() | 32'h1);
			write_reg(maop_pkg::REG_PERIOD, period);
			for (int m = 0; m < 3; m++) begin
				case (ph)
					3: thr = '0;
					4: thr = LVL_MAX;
					default: thr = rand_lvl();
				endcase
				write_reg(maop_pkg::REG_THR_FRONT + maop_pkg::IDX_W'(m),
					($urandom() & ~LVL_MASK) | maop_pkg::CFG_W'(thr));
			end
			write_spare();

			// phase 1 fills the block under a long receiver hold-off;
			// phase 2 runs with no idling on either side
			tx_idle = (ph != 1) && (ph != 2);
			rx_idle = (ph != 2);
			if (ph == 1)
				rx_hold_cycles = HOLD_CYCLES;

			now = $urandom();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 80) begin
					// mostly just past the period, sometimes one ms short
					off = ($urandom_range(9) == 0) ? -1 : int'($urandom_range(3));
					now = now + period + off;
				end else begin
					now = $urandom();
				end
				rand_poll(now);
			end
			drain_results();
		end

		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
